[rtl/core/utf8d_pkg.sv]
// Shared types, constants and decode functions of the UTF-8 stream decoder.
package utf8d_pkg;

    // Default depth of the queue between the front and back ends.
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

    // Sequence lengths announced by a lead byte.
    localparam logic [2:0] LEN_INVALID = 3'd0;
    localparam logic [2:0] LEN_SINGLE  = 3'd1;
    localparam logic [2:0] LEN_2B      = 3'd2;
    localparam logic [2:0] LEN_3B      = 3'd3;
    localparam logic [2:0] LEN_4B      = 3'd4;

    // One unit of work for the back end: the bytes to decode, how many of
    // them are present, and whether they close the text.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            end_of_text;
    } utf8d_entry_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b inside {8'b0???????}) begin
            len = LEN_SINGLE;
        end
        else if (b inside {8'b110?????}) begin
            len = LEN_2B;
        end
        else if (b inside {8'b1110????}) begin
            len = LEN_3B;
        end
        else if (b inside {8'b11110???}) begin
            len = LEN_4B;
        end
        else begin
            len = LEN_INVALID;
        end
        return len;
    endfunction

    // Builds a code point from a lead and its following bytes.
    function automatic logic [20:0] assemble(input logic [3:0][7:0] w, input logic [2:0] len);
        logic [20:0] cp;
        case (len)
            LEN_2B:  cp = {10'd0, w[0][4:0], w[1][5:0]};
            LEN_3B:  cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
            default: cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
        endcase
        return cp;
    endfunction

endpackage

[rtl/core/utf8_stream_decoder_core.sv]
// Top level of the UTF-8 stream decoder: front end, work queue and back end.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+------------------------------------------
//   input   | in        | in_valid / in_ready | text_byte, end_of_text
//   output  | out       | out_valid/out_ready | code_point, invalid_lead, last_of_text
//
// The input takes one byte per cycle whenever the work queue has room; a byte
// that only extends an open sequence produces no queue entry.
// The back end delivers one code point per cycle unless out_ready stalls it, so a
// normal byte stream runs at one transfer per cycle on both sides. A text that ends
// inside a sequence yields up to three code points for its last byte, produced by the back end walk.
// Output stalls fill the queue and then drop in_ready; they never lose data.
// Reset clears the front end counters, the queue pointers and the output valid.
module utf8_stream_decoder_core #(
    parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [20:0] code_point,
    output logic        invalid_lead,
    output logic        last_of_text,
    output logic        out_valid,
    input  logic        out_ready
);
    import utf8d_pkg::*;

    // Work handed from the front end to the queue.
    logic         push;
    utf8d_entry_t push_entry;
    logic         q_full;

    // Work handed from the queue to the back end.
    logic         head_valid;
    utf8d_entry_t head_entry;
    logic         pop;

    // The front end tracks pending sequence bytes and decides, per byte,
    // whether decode work is ready: a single byte, a bad lead, a finished
    // sequence, or everything still buffered when the text ends.
    utf8d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_byte  (text_byte),
        .end_of_text(end_of_text),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // The queue decouples the two ends so each can stall independently.
    utf8d_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .full      (q_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_entry(head_entry)
    );

    // The back end decodes one code point per cycle from the queue head while its output is not
    // stalled, and holds it in the output register until the transfer completes.
    utf8d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_point  (code_point),
        .invalid_lead(invalid_lead),
        .last_of_text(last_of_text)
    );

endmodule

[rtl/core/utf8d_front.sv]
// Front end: accepts bytes, gathers open sequences and queues decode work.
module utf8d_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [7:0]              text_byte,
    input  logic                    end_of_text,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    q_full,
    output logic                    push,
    output utf8d_pkg::utf8d_entry_t push_entry
);
    import utf8d_pkg::*;

    logic [2:0][7:0] pend_bytes_reg;
    logic [1:0]      pend_count_reg;
    logic [1:0]      pend_count_next;
    logic [2:0]      seq_len_reg;
    logic [2:0]      seq_len_next;

    logic            accept;
    logic [2:0]      lead_len;
    logic [2:0]      n_bytes;
    logic            hold;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign lead_len = lead_length(text_byte);
    assign n_bytes  = {1'b0, pend_count_reg} + 3'd1;

    // The byte stays buffered when it opens a sequence or does not yet complete one.
    always_comb
    begin
        if (pend_count_reg == 2'd0) begin
            hold = (lead_len != LEN_SINGLE) && (lead_len != LEN_INVALID);
        end
        else begin
            hold = n_bytes < seq_len_reg;
        end
    end

    assign push = accept && (end_of_text || !hold);

    always_comb
    begin
        push_entry.bytes = '0;
        for (int j = 0; j < 3; j++) begin
            if (2'(j) < pend_count_reg) begin
                push_entry.bytes[j] = pend_bytes_reg[j];
            end
        end
        push_entry.bytes[pend_count_reg] = text_byte;
        push_entry.count       = n_bytes;
        push_entry.end_of_text = end_of_text;
    end

    always_comb
    begin
        pend_count_next = pend_count_reg;
        seq_len_next    = seq_len_reg;
        if (accept) begin
            if (push) begin
                pend_count_next = 2'd0;
                seq_len_next    = 3'd0;
            end
            else begin
                pend_count_next = pend_count_reg + 2'd1;
                if (pend_count_reg == 2'd0) begin
                    seq_len_next = lead_len;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_count_reg <= 2'd0;
            seq_len_reg    <= 3'd0;
        end
        else begin
            pend_count_reg <= pend_count_next;
            seq_len_reg    <= seq_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !push && (pend_count_reg != 2'd3)) begin
            pend_bytes_reg[pend_count_reg] <= text_byte;
        end
    end

endmodule

[rtl/core/utf8d_queue.sv]
// Small first-in first-out queue of decode work between front and back ends.
module utf8d_queue #(
    parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  utf8d_pkg::utf8d_entry_t push_entry,
    output logic                    full,
    input  logic                    pop,
    output logic                    head_valid,
    output utf8d_pkg::utf8d_entry_t head_entry
);
    import utf8d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    utf8d_entry_t     slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = count_reg == FULL_CNT;
    assign head_valid = count_reg != '0;
    assign head_entry = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/core/utf8d_back.sv]
// Back end: walks queued bytes and produces one code point per cycle unless the output stalls.
module utf8d_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  utf8d_pkg::utf8d_entry_t head_entry,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [20:0]             code_point,
    output logic                    invalid_lead,
    output logic                    last_of_text
);
    import utf8d_pkg::*;

    logic [1:0]      pos_reg;
    logic [1:0]      pos_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [20:0]     code_point_reg;
    logic            invalid_lead_reg;
    logic            last_of_text_reg;

    logic [3:0][7:0] win;
    logic [2:0]      len;
    logic [3:0]      seq_end;
    logic            single;
    logic            fits;
    logic [2:0]      adv;
    logic [3:0]      end_pos;
    logic            done;
    logic            load;
    logic [20:0]     cp;

    // Window of the entry starting at the current walk position.
    always_comb
    begin
        for (int j = 0; j < 4; j++) begin
            win[j] = head_entry.bytes[pos_reg + 2'(j)];
        end
    end

    assign len     = lead_length(win[0]);
    assign single  = len == LEN_SINGLE;
    assign seq_end = {2'b00, pos_reg} + {1'b0, len};
    assign fits    = (len != LEN_INVALID) && (seq_end <= {1'b0, head_entry.count});
    assign adv     = (fits && !single) ? len : 3'd1;
    assign end_pos = {2'b00, pos_reg} + {1'b0, adv};
    assign done    = end_pos >= {1'b0, head_entry.count};

    always_comb
    begin
        if (single) begin
            cp = {13'd0, win[0]};
        end
        else if (fits) begin
            cp = assemble(win, len);
        end
        else begin
            cp = REPLACEMENT_CP;
        end
    end

    assign load = head_valid && (!out_valid_reg || out_ready);
    assign pop  = load && done;

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load) begin
            out_valid_next = 1'b1;
            pos_next       = done ? 2'd0 : end_pos[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            code_point_reg   <= cp;
            invalid_lead_reg <= !fits;
            last_of_text_reg <= head_entry.end_of_text && done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign code_point   = code_point_reg;
    assign invalid_lead = invalid_lead_reg;
    assign last_of_text = last_of_text_reg;

endmodule

[test/tb_top.sv]
// Self-checking testbench for the UTF-8 stream decoder core with random flow control.
`timescale 1ns / 100ps

module tb_top;

    import utf8d_pkg::*;

    // The limit lies far above any correct run, so this only catches a hang.
    localparam int CYCLE_LIMIT   = 200000;
    // Minimum number of random input bytes that follow the directed part.
    localparam int RANDOM_BYTES  = 120;
    // Cycles the receiver refuses every transfer during the back-pressure phase.
    localparam int HOLD_OFF_LEN  = 150;
    // Quiet cycles after the last expected code point, to catch extra output.
    localparam int TAIL_CYCLES   = 20;

    // One byte of text as the sender offers it.
    typedef struct {
        logic [7:0] value;
        logic       closes;
    } text_item_t;

    // One decoded code point as the block must deliver it.
    typedef struct {
        logic [20:0] cp;
        logic        bad;
        logic        fin;
    } decoded_cp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [7:0]  text_byte = 8'd0;
    logic        end_of_text = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [20:0] code_point;
    logic        invalid_lead;
    logic        last_of_text;
    logic        out_valid;
    logic        out_ready = 1'b0;

    // Bytes still to be offered, and code points still to be received.
    text_item_t  byte_feed[$];
    decoded_cp_t expected_cps[$];

    int mismatch_count = 0;
    int bytes_accepted = 0;
    int cycle_count    = 0;

    // Predictor state: the unfinished sequence and the length its lead announced.
    logic [7:0] held_bytes[0:2] = '{8'd0, 8'd0, 8'd0};
    int         held_count = 0;
    int         open_len   = 0;

    // Driver bookkeeping. byte_taken is set at the rising edge of a transfer
    // and read at the next falling edge, so the two never meet in one step.
    bit byte_taken = 1'b0;
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver stall pattern and the long hold-off that forces back-pressure.
    logic hold_off  = 1'b0;
    int   stall_span = 0;
    int   stall_mode = 0;

    utf8_stream_decoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .code_point   (code_point),
        .invalid_lead (invalid_lead),
        .last_of_text (last_of_text),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

    always #10 clk = ~clk;

    // Classifies a lead byte: single byte, start of a 2, 3 or 4 byte
    // sequence, or a byte that cannot start anything.
    function automatic logic [2:0] lead_span(input logic [7:0] b);
        logic [2:0] len;
        casez (b)
            8'b0???????: len = LEN_SINGLE;
            8'b110?????: len = LEN_2B;
            8'b1110????: len = LEN_3B;
            8'b11110???: len = LEN_4B;
            default:     len = LEN_INVALID;
        endcase
        return len;
    endfunction

    // Joins the payload bits of a lead at win[first] and the len-1 bytes
    // after it. Following bytes give their low six bits, whatever their prefix.
    function automatic logic [20:0] join_code_point(input logic [7:0] win[0:3],
                                                    input int first, input int len);
        logic [20:0] cp;
        int          i;
        if (len == LEN_2B) begin
            cp = 21'(win[first][4:0]);
        end
        else if (len == LEN_3B) begin
            cp = 21'(win[first][3:0]);
        end
        else begin
            cp = 21'(win[first][2:0]);
        end
        for (i = 1; i < len; i++) begin
            cp = (cp << 6) | 21'(win[first + i][5:0]);
        end
        return cp;
    endfunction

    // Advances the predictor by one accepted byte and queues the code points
    // that this byte releases.
    task automatic decode_byte(input logic [7:0] b, input logic closes);
        logic [7:0]  win[0:3];
        logic [2:0]  len;
        int          n;
        int          i;
        int          k;
        decoded_cp_t r;
        win = '{8'd0, 8'd0, 8'd0, 8'd0};
        for (i = 0; i < held_count; i++) begin
            win[i] = held_bytes[i];
        end
        win[held_count] = b;
        n = held_count + 1;

        if (!closes) begin
            if (held_count == 0) begin
                len = lead_span(b);
                if (len == LEN_SINGLE) begin
                    expected_cps.push_back('{21'(b), 1'b0, 1'b0});
                end
                else if (len == LEN_INVALID) begin
                    expected_cps.push_back('{REPLACEMENT_CP, 1'b1, 1'b0});
                end
                else begin
                    held_bytes[0] = b;
                    held_count    = 1;
                    open_len      = len;
                end
            end
            else if (n >= open_len) begin
                expected_cps.push_back('{join_code_point(win, 0, open_len), 1'b0, 1'b0});
                held_count = 0;
                open_len   = 0;
            end
            else begin
                held_bytes[held_count] = b;
                held_count++;
            end
        end
        else begin
            // End of text: everything buffered is decoded now. A lead that
            // lacks its following bytes becomes a replacement and the walk
            // restarts on the very next byte.
            i = 0;
            k = 0;
            while (i < n && k < 3) begin
                len = lead_span(win[i]);
                r.bad = 1'b0;
                if (len == LEN_SINGLE) begin
                    r.cp = 21'(win[i]);
                    i += 1;
                end
                else if (len != LEN_INVALID && i + len <= n) begin
                    r.cp = join_code_point(win, i, len);
                    i += len;
                end
                else begin
                    r.cp  = REPLACEMENT_CP;
                    r.bad = 1'b1;
                    i += 1;
                end
                r.fin = (i >= n);
                expected_cps.push_back(r);
                k++;
            end
            held_count = 0;
            open_len   = 0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic queue_byte(input logic [7:0] v, input logic closes);
        byte_feed.push_back('{v, closes});
    endtask

    // Sender: at each falling edge, once the previous byte has gone (or
    // nothing was offered), either idle through a gap or offer the next byte.
    // Bursts and gaps have random lengths; some gaps are zero so that long
    // back-to-back stretches occur as well.
    always @(negedge clk) begin
        text_item_t item;
        logic       next_valid;
        if (rst_n && (!in_valid || byte_taken)) begin
            byte_taken = 1'b0;
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end
            else if (byte_feed.size() != 0) begin
                item = byte_feed.pop_front();
                text_byte   <= item.value;
                end_of_text <= item.closes;
                next_valid  = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end
                else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            in_valid <= next_valid;
        end
    end

    // Input side of the transfer: every accepted byte goes into the predictor.
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            decode_byte(text_byte, end_of_text);
            bytes_accepted++;
            byte_taken = 1'b1;
        end
    end

    // Receiver: the stall pattern changes at random intervals between
    // always ready, a coin toss, and mostly ready. The hold-off overrides it.
    always @(negedge clk) begin
        logic ready;
        if (stall_span == 0) begin
            stall_span = $urandom_range(8, 40);
            stall_mode = $urandom_range(0, 2);
        end
        else begin
            stall_span--;
        end
        case (stall_mode)
            0:       ready = 1'b1;
            1:       ready = 1'($urandom_range(0, 1));
            default: ready = ($urandom_range(0, 3) != 0);
        endcase
        out_ready <= rst_n && !hold_off && ready;
    end

    // Once the random stream is well under way, the receiver refuses every
    // transfer for a long stretch. The sender keeps offering bytes, so the
    // work queue fills and in_ready must drop without losing anything.
    initial begin
        while (bytes_accepted < 40) begin
            @(posedge clk);
        end
        hold_off <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Output side of the transfer: each code point is checked against the
    // oldest expectation, field by field.
    always @(posedge clk) begin
        decoded_cp_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_cps.size() == 0) begin
                report_mismatch($sformatf("unexpected code point %h", code_point));
            end
            else begin
                want = expected_cps.pop_front();
                if (code_point !== want.cp) begin
                    report_mismatch($sformatf("code_point %h, want %h", code_point, want.cp));
                end
                if (invalid_lead !== want.bad) begin
                    report_mismatch($sformatf("invalid_lead %b, want %b (cp %h)",
                                              invalid_lead, want.bad, want.cp));
                end
                if (last_of_text !== want.fin) begin
                    report_mismatch($sformatf("last_of_text %b, want %b (cp %h)",
                                              last_of_text, want.fin, want.cp));
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        logic [7:0] chunk[$];
        int         chars;
        int         c;
        int         kind;
        int         span;
        int         cut;
        int         k;

        // Directed part: field extremes and the zero byte as a plain byte.
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h00, 1'b0);
        // Two byte sequences: a normal one, a zero byte as the follower
        // (no 10 prefix check), and an overlong form.
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'hA9, 1'b0);
        queue_byte(8'hC2, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hC0, 1'b0);
        queue_byte(8'h80, 1'b0);
        // Three byte sequence, then the largest four byte value.
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h82, 1'b0);
        queue_byte(8'hAC, 1'b0);
        queue_byte(8'hF7, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b0);
        // Invalid leads: stray follower bytes and leads above 11110xxx.
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hF8, 1'b0);
        // Truncated text with two nested short leads: three code points
        // come out of the closing byte.
        queue_byte(8'hF4, 1'b0);
        queue_byte(8'hE0, 1'b0);
        queue_byte(8'h41, 1'b1);
        // A text that is only a lead, and a text closed by a plain byte.
        queue_byte(8'hC3, 1'b1);
        queue_byte(8'h41, 1'b1);

        // Random part: texts of a few characters, mostly well-formed
        // sequences with random payload, plus invalid leads, corrupted
        // followers, raw noise, and texts that stop inside their last
        // character.
        while (byte_feed.size() < 24 + RANDOM_BYTES) begin
            chars = $urandom_range(1, 10);
            for (c = 0; c < chars; c++) begin
                chunk.delete();
                kind = $urandom_range(0, 99);
                if (kind < 40) begin
                    chunk.push_back(8'($urandom_range(1, 127)));
                end
                else if (kind < 80) begin
                    span = (kind < 55) ? 2 : (kind < 70) ? 3 : 4;
                    if (span == 2) begin
                        chunk.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                    end
                    else if (span == 3) begin
                        chunk.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                    end
                    else begin
                        chunk.push_back(8'hF0 | 8'($urandom_range(0, 7)));
                    end
                    for (k = 1; k < span; k++) begin
                        if ($urandom_range(0, 9) == 0) begin
                            chunk.push_back(8'($urandom_range(1, 255)));
                        end
                        else begin
                            chunk.push_back(8'h80 | 8'($urandom_range(0, 63)));
                        end
                    end
                    if (c == chars - 1 && $urandom_range(0, 2) == 0) begin
                        cut = $urandom_range(1, span - 1);
                        while (chunk.size() > cut) begin
                            void'(chunk.pop_back());
                        end
                    end
                end
                else if (kind < 90) begin
                    if ($urandom_range(0, 1) == 0) begin
                        chunk.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    end
                    else begin
                        chunk.push_back(8'($urandom_range(8'hF8, 8'hFF)));
                    end
                end
                else begin
                    chunk.push_back(8'($urandom_range(1, 255)));
                end
                foreach (chunk[j]) begin
                    queue_byte(chunk[j], (c == chars - 1) && (j == chunk.size() - 1));
                end
            end
        end

        // Reset is asserted from time zero and released on a falling edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the sender to run dry, then for the decoder to drain.
        while (byte_feed.size() != 0 || in_valid) begin
            @(posedge clk);
        end
        while (expected_cps.size() != 0) begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("tb_top: clean");
        end
        else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
